@@ sv/wmc_pkg.sv @@
// ----------------------------------------------------------------------------
// wmc_pkg
// Shared types and constants of the watch mode and time-set controller.
// ----------------------------------------------------------------------------
package wmc_pkg;

  // Tick counter width; tick differences wrap modulo 2^TICK_W
  localparam int TICK_W    = 32;
  localparam int NOW_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int CUR_W     = 2;

  localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
  localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);

  // Cursor codes; both cursors wrap after the last entry
  localparam logic [CUR_W-1:0] CUR_LAST   = CUR_W'(2);
  localparam logic [CUR_W-1:0] EDIT_HOUR  = CUR_W'(0);
  localparam logic [CUR_W-1:0] EDIT_MIN   = CUR_W'(1);
  localparam logic [CUR_W-1:0] EDIT_SAVE  = CUR_W'(2);

  localparam logic [CFG_W-1:0] TIMEOUT_RST      = CFG_W'(5000);
  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST = CFG_W'(500);
  localparam logic [CFG_W-1:0] REPEAT_INTVL_RST = CFG_W'(100);

  typedef enum logic [2:0] {
    MODE_CLOCK    = 3'd0,
    MODE_SET      = 3'd1,
    MODE_SENSORS  = 3'd2,
    MODE_MENU     = 3'd3,
    MODE_INACTIVE = 3'd4
  } wmc_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT      = 2'd0,
    REG_REPEAT_DELAY = 2'd1,
    REG_REPEAT_INTVL = 2'd2
  } wmc_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] timeout;
    logic [CFG_W-1:0] repeat_delay;
    logic [CFG_W-1:0] repeat_intvl;
  } wmc_cfg_t;

  typedef struct packed {
    wmc_mode_t         mode;
    logic [CUR_W-1:0]  menu_pos;
    logic [CUR_W-1:0]  edit_pos;
    logic              sel_pend;
    logic [TICK_W-1:0] last_act;
    logic              btn_was_held;
    logic [TICK_W-1:0] press_start;
    logic [TICK_W-1:0] last_repeat;
    logic              disp_en;
  } wmc_state_t;

  typedef struct packed {
    logic [NOW_W-1:0]  now_ms;
    logic              button_held;
    logic              select_main_event;
    logic              select_aux_event;
    logic              wake_event;
    logic [HOUR_W-1:0] clock_hours;
    logic [MIN_W-1:0]  clock_minutes;
  } wmc_item_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [CUR_W-1:0]  menu_cursor;
    logic [CUR_W-1:0]  edit_field;
    logic [HOUR_W-1:0] new_hours;
    logic [MIN_W-1:0]  new_minutes;
    logic              time_write;
    logic              display_on;
  } wmc_result_t;

endpackage

@@ sv/wmc_if.sv @@
// ----------------------------------------------------------------------------
// wmc_in_if / wmc_out_if
// Valid/ready channels carrying poll requests and result requests.
// ----------------------------------------------------------------------------
interface wmc_in_if;
  import wmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [NOW_W-1:0]  now_ms;
  logic              button_held;
  logic              select_main_event;
  logic              select_aux_event;
  logic              wake_event;
  logic [HOUR_W-1:0] clock_hours;
  logic [MIN_W-1:0]  clock_minutes;

  modport source (
    output valid, now_ms, button_held, select_main_event, select_aux_event,
           wake_event, clock_hours, clock_minutes,
    input  ready
  );
  modport sink (
    input  valid, now_ms, button_held, select_main_event, select_aux_event,
           wake_event, clock_hours, clock_minutes,
    output ready
  );
endinterface

interface wmc_out_if;
  import wmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [CUR_W-1:0]  menu_cursor;
  logic [CUR_W-1:0]  edit_field;
  logic [HOUR_W-1:0] new_hours;
  logic [MIN_W-1:0]  new_minutes;
  logic              time_write;
  logic              display_on;

  modport source (
    output valid, mode, menu_cursor, edit_field, new_hours, new_minutes,
           time_write, display_on,
    input  ready
  );
  modport sink (
    input  valid, mode, menu_cursor, edit_field, new_hours, new_minutes,
           time_write, display_on,
    output ready
  );
endinterface

@@ sv/wmc_step.sv @@
// ----------------------------------------------------------------------------
// wmc_step
// One poll of the mode machine: next controller state and the result request.
// ----------------------------------------------------------------------------
module wmc_step (
  input  wmc_pkg::wmc_cfg_t    cfg,
  input  wmc_pkg::wmc_state_t  state,
  input  wmc_pkg::wmc_item_t   item,
  output wmc_pkg::wmc_state_t  state_nxt,
  output wmc_pkg::wmc_result_t result
);
  import wmc_pkg::*;

  function automatic logic [CUR_W-1:0] cur_adv(input logic [CUR_W-1:0] c);
    cur_adv = (c == CUR_LAST) ? '0 : c + CUR_W'(1);
  endfunction

  logic [TICK_W-1:0] now;
  logic [TICK_W-1:0] last_act_a;
  logic [TICK_W-1:0] last_act_b;
  logic [TICK_W-1:0] idle_ms;
  logic [TICK_W-1:0] held_ms;
  logic [TICK_W-1:0] since_rep_ms;
  logic              sel_pend_a;
  logic              sel_pend_b;
  logic              timeout_hit;
  logic              press_edge;
  logic              repeat_due;
  logic              wake_any;
  logic              bump;
  wmc_mode_t         mode_a;
  wmc_mode_t         mode_nxt;
  logic [CUR_W-1:0]  edit_pos_a;
  wmc_state_t        st;
  logic [HOUR_W-1:0] hours;
  logic [MIN_W-1:0]  minutes;

  // Record select events, then check for inactivity timeout
  assign now         = item.now_ms[TICK_W-1:0];
  assign sel_pend_a  = state.sel_pend | item.select_main_event | item.select_aux_event;
  assign last_act_a  = item.select_main_event ? now : state.last_act;
  assign idle_ms     = now - last_act_a;
  assign timeout_hit = idle_ms >= {{(TICK_W-CFG_W){1'b0}}, cfg.timeout};
  assign mode_a      = timeout_hit ? MODE_INACTIVE : state.mode;
  assign sel_pend_b  = timeout_hit ? 1'b0 : sel_pend_a;
  assign last_act_b  = timeout_hit ? now : last_act_a;

  // Set-time cursor moves before the press is evaluated
  assign edit_pos_a = (mode_a == MODE_SET && sel_pend_b) ? cur_adv(state.edit_pos)
                                                         : state.edit_pos;

  // Press and auto-repeat timing
  assign held_ms      = now - state.press_start;
  assign since_rep_ms = now - state.last_repeat;
  assign press_edge   = item.button_held & ~state.btn_was_held;
  assign repeat_due   = item.button_held & state.btn_was_held &
                        (held_ms > {{(TICK_W-CFG_W){1'b0}}, cfg.repeat_delay}) &
                        (since_rep_ms > {{(TICK_W-CFG_W){1'b0}}, cfg.repeat_intvl});
  assign bump         = (mode_a == MODE_SET) & (press_edge | repeat_due) &
                        (edit_pos_a != EDIT_SAVE);
  assign wake_any     = item.wake_event | sel_pend_b | item.button_held;

  // Next mode
  always_comb begin
    mode_nxt = mode_a;
    unique case (mode_a)
      MODE_CLOCK: begin
        if (item.button_held) mode_nxt = MODE_MENU;
      end
      MODE_MENU: begin
        if (item.button_held) mode_nxt = wmc_mode_t'({1'b0, state.menu_pos});
      end
      MODE_SET: begin
        if (press_edge && edit_pos_a == EDIT_SAVE) mode_nxt = MODE_MENU;
      end
      MODE_INACTIVE: begin
        if (wake_any) mode_nxt = MODE_CLOCK;
      end
      default: mode_nxt = mode_a;
    endcase
  end

  // Cursors, timers, display and time increment
  always_comb begin
    st          = state;
    st.mode     = mode_nxt;
    st.sel_pend = sel_pend_b;
    st.last_act = last_act_b;
    st.edit_pos = edit_pos_a;
    hours       = item.clock_hours;
    minutes     = item.clock_minutes;
    case (mode_a)
      MODE_CLOCK: begin
        if (item.button_held) st.last_act = now;
      end
      MODE_MENU: begin
        if (item.button_held) st.last_act = now;
        if (sel_pend_b) begin
          st.menu_pos = cur_adv(state.menu_pos);
          st.sel_pend = 1'b0;
        end
      end
      MODE_SET: begin
        if (sel_pend_b) st.sel_pend = 1'b0;
        if (item.button_held) begin
          st.last_act = now;
          if (press_edge) begin
            st.press_start = now;
            st.last_repeat = now;
          end else if (repeat_due) begin
            st.last_repeat = now;
          end
        end else begin
          st.press_start = '0;
          st.last_repeat = '0;
        end
        st.btn_was_held = item.button_held;
      end
      MODE_INACTIVE: begin
        st.disp_en = wake_any;
        if (wake_any) st.last_act = now;
      end
      default: ;
    endcase
    if (bump) begin
      if (edit_pos_a == EDIT_HOUR) begin
        hours = (item.clock_hours < HOUR_MAX) ? item.clock_hours + HOUR_W'(1) : '0;
      end else begin
        minutes = (item.clock_minutes < MIN_MAX) ? item.clock_minutes + MIN_W'(1) : '0;
      end
    end
  end

  assign state_nxt = st;

  assign result.mode        = st.mode;
  assign result.menu_cursor = st.menu_pos;
  assign result.edit_field  = st.edit_pos;
  assign result.new_hours   = hours;
  assign result.new_minutes = minutes;
  assign result.time_write  = bump;
  assign result.display_on  = st.disp_en;

endmodule

@@ sv/watch_mode_and_time_set_controller.sv @@
// ----------------------------------------------------------------------------
// watch_mode_and_time_set_controller
// Mode machine of a watch: clock, menu, set-time and inactive modes.
// ----------------------------------------------------------------------------
// Each poll request is registered, stepped through the mode machine and its
// result request registered. While out_port.ready stays high, a new poll is
// accepted every cycle. While a finished result waits on out_port.ready, one
// more poll is taken into the input register, and then in_port.ready stays
// low until the waiting result is accepted. The rate is set by the loop
// through the controller state registers; each poll sees the state left by
// the one before it. Configuration writes take effect for polls stepped after
// the write.
module watch_mode_and_time_set_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  wmc_in_if.sink                           in_port,
  wmc_out_if.source                        out_port,
  input  logic                             cfg_we,
  input  logic [wmc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [wmc_pkg::CFG_W-1:0]        cfg_wdata
);
  import wmc_pkg::*;

  wmc_cfg_t    cfg_r;
  wmc_state_t  state_r;
  wmc_state_t  state_nxt;
  wmc_item_t   in_item_r;
  logic        in_valid_r;
  wmc_result_t res_r;
  wmc_result_t result;
  logic        out_valid_r;
  logic        advance;
  logic        in_take;

  // Step the registered poll when the result register is free or being read
  assign advance       = in_valid_r & (~out_valid_r | out_port.ready);
  assign in_port.ready = ~in_valid_r | advance;
  assign in_take       = in_port.valid & in_port.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout      <= TIMEOUT_RST;
      cfg_r.repeat_delay <= REPEAT_DELAY_RST;
      cfg_r.repeat_intvl <= REPEAT_INTVL_RST;
    end else if (cfg_we) begin
      unique case (wmc_reg_t'(cfg_idx))
        REG_TIMEOUT:      cfg_r.timeout      <= cfg_wdata;
        REG_REPEAT_DELAY: cfg_r.repeat_delay <= cfg_wdata;
        REG_REPEAT_INTVL: cfg_r.repeat_intvl <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the input request
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.now_ms            <= in_port.now_ms;
      in_item_r.button_held       <= in_port.button_held;
      in_item_r.select_main_event <= in_port.select_main_event;
      in_item_r.select_aux_event  <= in_port.select_aux_event;
      in_item_r.wake_event        <= in_port.wake_event;
      in_item_r.clock_hours       <= in_port.clock_hours;
      in_item_r.clock_minutes     <= in_port.clock_minutes;
    end
  end

  // Controller state and channel valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r           <= 1'b0;
      out_valid_r          <= 1'b0;
      state_r.mode         <= MODE_CLOCK;
      state_r.menu_pos     <= '0;
      state_r.edit_pos     <= '0;
      state_r.sel_pend     <= 1'b0;
      state_r.last_act     <= '0;
      state_r.btn_was_held <= 1'b0;
      state_r.press_start  <= '0;
      state_r.last_repeat  <= '0;
      state_r.disp_en      <= 1'b1;
    end else begin
      if (in_take)      in_valid_r <= 1'b1;
      else if (advance) in_valid_r <= 1'b0;
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_port.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  wmc_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Hold the result request
  always_ff @(posedge clk) begin
    if (advance) res_r <= result;
  end

  assign out_port.valid       = out_valid_r;
  assign out_port.mode        = res_r.mode;
  assign out_port.menu_cursor = res_r.menu_cursor;
  assign out_port.edit_field  = res_r.edit_field;
  assign out_port.new_hours   = res_r.new_hours;
  assign out_port.new_minutes = res_r.new_minutes;
  assign out_port.time_write  = res_r.time_write;
  assign out_port.display_on  = res_r.display_on;

  // Display is off exactly in the inactive mode
  a_disp_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.mode == MODE_INACTIVE) == !res_r.display_on))
    else $error("display enable disagrees with mode");

  // A time write only comes from set-time mode
  a_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.time_write) |-> (res_r.mode == MODE_SET))
    else $error("time write outside set-time mode");

  // Cursors never reach the unused code
  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.menu_pos != 2'd3) && (state_r.edit_pos != 2'd3))
    else $error("cursor out of range");

  // State moves only when a poll is stepped
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("state changed without a stepped poll");

endmodule

@@ verif/tb_watch_mode_and_time_set_controller.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_watch_mode_and_time_set_controller
// Self-checking bench for the watch mode and time-set controller. Poll requests
// go in through the valid/ready input channel. Every accepted poll is stepped
// through a behavioral copy of the mode machine, and each result request is
// checked field by field against the oldest predicted status. The run covers
// directed mode walks, register extremes, random traffic with idling on both
// sides, and a long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_watch_mode_and_time_set_controller;
  import wmc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS  = 40;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  wmc_in_if  poll_ch ();
  wmc_out_if status_ch ();

  watch_mode_and_time_set_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_port   (poll_ch),
    .out_port  (status_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Controller copy: registers and state
  logic [CFG_W-1:0]  m_timeout;
  logic [CFG_W-1:0]  m_rep_delay;
  logic [CFG_W-1:0]  m_rep_intvl;
  wmc_mode_t         m_mode;
  logic [CUR_W-1:0]  m_menu;
  logic [CUR_W-1:0]  m_edit;
  logic              m_sel_pend;
  logic [TICK_W-1:0] m_last_act;
  logic              m_btn_was;
  logic [TICK_W-1:0] m_press_start;
  logic [TICK_W-1:0] m_last_rep;
  logic              m_disp;

  wmc_result_t       status_q[$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  int                idle_pct = 0;
  int                stall_pct = 0;

  // Result hold-off control
  int unsigned       hold_seq = 0;
  int unsigned       hold_seen = 0;
  int unsigned       hold_cnt = 0;

  // Random poll generator state
  logic [NOW_W-1:0]  gen_now;
  logic              gen_btn;

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive result ready: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      status_ch.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= HOLD_CYCLES;
      status_ch.ready <= 1'b0;
    end else begin
      status_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void reset_watch_model();
    m_timeout     = TIMEOUT_RST;
    m_rep_delay   = REPEAT_DELAY_RST;
    m_rep_intvl   = REPEAT_INTVL_RST;
    m_mode        = MODE_CLOCK;
    m_menu        = '0;
    m_edit        = EDIT_HOUR;
    m_sel_pend    = 1'b0;
    m_last_act    = '0;
    m_btn_was     = 1'b0;
    m_press_start = '0;
    m_last_rep    = '0;
    m_disp        = 1'b1;
  endfunction

  // Increment the field under the edit cursor; Save changes nothing
  function automatic logic advance_time_field(inout logic [HOUR_W-1:0] hh,
                                              inout logic [MIN_W-1:0] mm);
    if (m_edit == EDIT_HOUR) begin
      hh = (hh < HOUR_MAX) ? hh + 1'b1 : '0;
      return 1'b1;
    end
    if (m_edit == EDIT_MIN) begin
      mm = (mm < MIN_MAX) ? mm + 1'b1 : '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Step the controller copy by one poll and return the status it shows
  function automatic wmc_result_t step_watch(wmc_item_t p);
    logic [TICK_W-1:0] now;
    logic [HOUR_W-1:0] hh;
    logic [MIN_W-1:0]  mm;
    logic              wrote;
    logic [TICK_W-1:0] d_act;
    logic [TICK_W-1:0] d_press;
    logic [TICK_W-1:0] d_rep;
    wmc_result_t       r;
    now   = p.now_ms;
    hh    = p.clock_hours;
    mm    = p.clock_minutes;
    wrote = 1'b0;

    // Record select events
    if (p.select_main_event) begin
      m_sel_pend = 1'b1;
      m_last_act = now;
    end
    if (p.select_aux_event)
      m_sel_pend = 1'b1;

    // Inactivity timeout, modulo tick width
    d_act = now - m_last_act;
    if (d_act >= TICK_W'(m_timeout)) begin
      m_mode     = MODE_INACTIVE;
      m_last_act = now;
      m_sel_pend = 1'b0;
    end

    case (m_mode)
      MODE_CLOCK: begin
        if (p.button_held) begin
          m_mode     = MODE_MENU;
          m_last_act = now;
        end
      end
      MODE_MENU: begin
        // Enter the entry under the cursor before it moves
        if (p.button_held) begin
          m_mode     = wmc_mode_t'({1'b0, m_menu});
          m_last_act = now;
        end
        if (m_sel_pend) begin
          m_menu     = (m_menu == CUR_LAST) ? '0 : m_menu + 1'b1;
          m_sel_pend = 1'b0;
        end
      end
      MODE_SET: begin
        if (m_sel_pend) begin
          m_edit     = (m_edit == CUR_LAST) ? '0 : m_edit + 1'b1;
          m_sel_pend = 1'b0;
        end
        if (p.button_held) begin
          m_last_act = now;
          d_press = now - m_press_start;
          d_rep   = now - m_last_rep;
          if (!m_btn_was) begin
            if (m_edit == EDIT_SAVE)
              m_mode = MODE_MENU;
            else
              wrote = advance_time_field(hh, mm);
            m_press_start = now;
            m_last_rep    = now;
          end else if (d_press > TICK_W'(m_rep_delay) &&
                       d_rep > TICK_W'(m_rep_intvl)) begin
            wrote      = advance_time_field(hh, mm);
            m_last_rep = now;
          end
        end else begin
          m_press_start = '0;
          m_last_rep    = '0;
        end
        m_btn_was = p.button_held;
      end
      MODE_INACTIVE: begin
        m_disp = 1'b0;
        if (p.wake_event || m_sel_pend || p.button_held) begin
          m_mode     = MODE_CLOCK;
          m_disp     = 1'b1;
          m_last_act = now;
        end
      end
      default: ;
    endcase

    r.mode        = m_mode;
    r.menu_cursor = m_menu;
    r.edit_field  = m_edit;
    r.new_hours   = hh;
    r.new_minutes = mm;
    r.time_write  = wrote;
    r.display_on  = m_disp;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Predict on each accepted poll; check each accepted result request
  always @(posedge clk) begin : status_monitor
    wmc_item_t   p;
    wmc_result_t want;
    if (rst_n) begin
      if (status_ch.valid && status_ch.ready) begin
        if (status_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result request with no poll outstanding, mode %0d",
                     $time, status_ch.mode);
        end else begin
          want = status_q.pop_front();
          check_field("mode", 32'(want.mode), 32'(status_ch.mode));
          check_field("menu_cursor", 32'(want.menu_cursor), 32'(status_ch.menu_cursor));
          check_field("edit_field", 32'(want.edit_field), 32'(status_ch.edit_field));
          check_field("new_hours", 32'(want.new_hours), 32'(status_ch.new_hours));
          check_field("new_minutes", 32'(want.new_minutes), 32'(status_ch.new_minutes));
          check_field("time_write", 32'(want.time_write), 32'(status_ch.time_write));
          check_field("display_on", 32'(want.display_on), 32'(status_ch.display_on));
        end
      end
      if (poll_ch.valid && poll_ch.ready) begin
        p.now_ms            = poll_ch.now_ms;
        p.button_held       = poll_ch.button_held;
        p.select_main_event = poll_ch.select_main_event;
        p.select_aux_event  = poll_ch.select_aux_event;
        p.wake_event        = poll_ch.wake_event;
        p.clock_hours       = poll_ch.clock_hours;
        p.clock_minutes     = poll_ch.clock_minutes;
        status_q.push_back(step_watch(p));
      end
    end
  end

  // Offer one poll request after a random idle gap; return once accepted
  task automatic send_poll(input wmc_item_t p);
    while ($urandom_range(99) < idle_pct) begin
      poll_ch.valid <= 1'b0;
      @(posedge clk);
    end
    poll_ch.valid             <= 1'b1;
    poll_ch.now_ms            <= p.now_ms;
    poll_ch.button_held       <= p.button_held;
    poll_ch.select_main_event <= p.select_main_event;
    poll_ch.select_aux_event  <= p.select_aux_event;
    poll_ch.wake_event        <= p.wake_event;
    poll_ch.clock_hours       <= p.clock_hours;
    poll_ch.clock_minutes     <= p.clock_minutes;
    do @(posedge clk); while (!poll_ch.ready);
  endtask

  task automatic poll(input logic [NOW_W-1:0] t, input logic b, input logic sm,
                      input logic sa, input logic wk, input logic [HOUR_W-1:0] h,
                      input logic [MIN_W-1:0] m);
    wmc_item_t p;
    p.now_ms            = t;
    p.button_held       = b;
    p.select_main_event = sm;
    p.select_aux_event  = sa;
    p.wake_event        = wk;
    p.clock_hours       = h;
    p.clock_minutes     = m;
    send_poll(p);
  endtask

  // Mostly steady ticks with button runs; now and then a long or wild jump
  function automatic wmc_item_t make_random_poll();
    wmc_item_t   p;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3)
      gen_now = $urandom();
    else if (r < 8)
      gen_now = gen_now + $urandom_range(70000);
    else
      gen_now = gen_now + $urandom_range(250);
    if ($urandom_range(99) < 20)
      gen_btn = ~gen_btn;
    p.now_ms            = gen_now;
    p.button_held       = gen_btn;
    p.select_main_event = ($urandom_range(99) < 8);
    p.select_aux_event  = ($urandom_range(99) < 6);
    p.wake_event        = ($urandom_range(99) < 6);
    p.clock_hours       = ($urandom_range(99) < 5) ? HOUR_W'($urandom_range(31))
                                                   : HOUR_W'($urandom_range(23));
    p.clock_minutes     = ($urandom_range(99) < 5) ? MIN_W'($urandom_range(63))
                                                   : MIN_W'($urandom_range(59));
    return p;
  endfunction

  // Drop valid and wait until every predicted status has come back
  task automatic settle();
    poll_ch.valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input wmc_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_TIMEOUT:      m_timeout   = val;
      REG_REPEAT_DELAY: m_rep_delay = val;
      REG_REPEAT_INTVL: m_rep_intvl = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] timeout,
                              input logic [CFG_W-1:0] delay,
                              input logic [CFG_W-1:0] intvl);
    set_reg(REG_TIMEOUT, timeout);
    set_reg(REG_REPEAT_DELAY, delay);
    set_reg(REG_REPEAT_INTVL, intvl);
  endtask

  // Walk every mode at reset settings, including the edge cases
  task automatic test_directed_modes();
    idle_pct  = 0;
    stall_pct = 0;
    poll(32'd100,  1'b0, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59);
    poll(32'd200,  1'b1, 1'b0, 1'b0, 1'b0, 5'd0,  6'd0);   // clock -> menu
    poll(32'd300,  1'b0, 1'b1, 1'b0, 1'b0, 5'd12, 6'd30);  // cursor to set time
    poll(32'd400,  1'b1, 1'b0, 1'b1, 1'b0, 5'd23, 6'd10);  // enter, then cursor moves
    poll(32'd500,  1'b1, 1'b0, 1'b0, 1'b0, 5'd23, 6'd10);  // press: hour wraps
    poll(32'd550,  1'b1, 1'b0, 1'b0, 1'b0, 5'd5,  6'd10);  // inside repeat delay
    poll(32'd1100, 1'b1, 1'b0, 1'b0, 1'b0, 5'd5,  6'd10);  // first auto-repeat
    poll(32'd1150, 1'b1, 1'b0, 1'b0, 1'b0, 5'd6,  6'd10);  // inside repeat interval
    poll(32'd1300, 1'b1, 1'b0, 1'b0, 1'b0, 5'd31, 6'd10);  // out-of-range hour
    poll(32'd1400, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0,  6'd59);  // edit minute, release
    poll(32'd1500, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0,  6'd59);  // minute wraps
    poll(32'd1600, 1'b1, 1'b0, 1'b1, 1'b0, 5'd0,  6'd63);  // to Save while held
    poll(32'd2200, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0,  6'd63);  // repeat on Save: nothing
    poll(32'd2300, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0,  6'd63);
    poll(32'd2400, 1'b1, 1'b0, 1'b0, 1'b0, 5'd1,  6'd2);   // Save -> menu
    poll(32'd2500, 1'b1, 1'b0, 1'b0, 1'b0, 5'd1,  6'd2);   // menu -> sensors
    poll(32'd2600, 1'b1, 1'b0, 1'b0, 1'b1, 5'd1,  6'd2);   // sensors holds
    poll(32'd7600, 1'b0, 1'b0, 1'b0, 1'b0, 5'd1,  6'd3);   // timeout -> inactive
    poll(32'd7700, 1'b0, 1'b0, 1'b0, 1'b1, 5'd1,  6'd3);   // wake
    poll(32'd20000, 1'b1, 1'b0, 1'b0, 1'b0, 5'd2, 6'd0);   // timeout, held button wakes
    poll(32'd40000, 1'b0, 1'b0, 1'b0, 1'b0, 5'd2, 6'd0);   // timeout -> inactive
    poll(32'd40100, 1'b0, 1'b0, 1'b1, 1'b0, 5'd2, 6'd0);   // wake by select, kept
    poll(32'd40200, 1'b1, 1'b0, 1'b0, 1'b0, 5'd2, 6'd0);   // clock -> menu
    poll(32'd40300, 1'b0, 1'b0, 1'b0, 1'b0, 5'd2, 6'd0);   // menu takes the select
  endtask

  // A timeout register of zero fires on every poll
  task automatic test_register_extremes();
    settle();
    apply_config(16'd0, 16'd0, 16'd0);
    poll(32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0, 1'b0, 5'd4, 6'd4);
    poll(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 5'd4, 6'd4);
    poll(32'h0000_0001, 1'b0, 1'b1, 1'b0, 1'b1, 5'd4, 6'd4);
  endtask

  task automatic test_random_traffic(input int n, input int idle, input int stall,
                                     input logic [CFG_W-1:0] timeout,
                                     input logic [CFG_W-1:0] delay,
                                     input logic [CFG_W-1:0] intvl);
    settle();
    apply_config(timeout, delay, intvl);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_poll(make_random_poll());
  endtask

  // Hold off results for a long stretch while polls keep coming
  task automatic test_input_backpressure(input int n);
    settle();
    idle_pct  = 0;
    stall_pct = 0;
    hold_seq <= hold_seq + 1;
    repeat (n) send_poll(make_random_poll());
  endtask

  initial begin
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_idx                   = REG_TIMEOUT;
    cfg_wdata                 = '0;
    poll_ch.valid             = 1'b0;
    poll_ch.now_ms            = '0;
    poll_ch.button_held       = 1'b0;
    poll_ch.select_main_event = 1'b0;
    poll_ch.select_aux_event  = 1'b0;
    poll_ch.wake_event        = 1'b0;
    poll_ch.clock_hours       = '0;
    poll_ch.clock_minutes     = '0;
    status_ch.ready           = 1'b0;
    gen_now                   = '0;
    gen_btn                   = 1'b0;
    reset_watch_model();

    // Hold reset, then release it
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_modes();
    test_register_extremes();
    test_random_traffic(200, 0, 0, TIMEOUT_RST, REPEAT_DELAY_RST, REPEAT_INTVL_RST);
    test_random_traffic(150, 74, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_traffic(100, 0, 74, 16'd1, 16'd0, 16'd0);
    test_random_traffic(250, 22, 22, CFG_W'($urandom_range(400, 20000)),
                        CFG_W'($urandom_range(1500)), CFG_W'($urandom_range(400)));
    test_input_backpressure(80);
    test_random_traffic(250, 0, 0, CFG_W'($urandom_range(400, 20000)),
                        CFG_W'($urandom_range(1500)), CFG_W'($urandom_range(400)));
    test_random_traffic(200, 22, 22, 16'd3000, 16'd300, 16'd50);
    settle();

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/wmc_pkg.sv
sv/wmc_if.sv
sv/wmc_step.sv
sv/watch_mode_and_time_set_controller.sv
verif/tb_watch_mode_and_time_set_controller.sv
